@@ rtl/devq_pkg.sv @@
// ----------------------------------------------------------------------------
// devq_pkg
// Shared types, sizes and helpers for the device event queue with its
// event memory.
// ----------------------------------------------------------------------------
package devq_pkg;

   // Queue and event memory sizes
   localparam int QUEUE_DEPTH  = 8;
   localparam int MEMORY_SLOTS = 6;
   localparam int MEM_BYTES    = 1 + 3 * MEMORY_SLOTS;

   localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   // Event memory byte constants
   localparam logic [7:0] STATUS_BASE = 8'h80;
   localparam logic [7:0] QUAL_BASE   = 8'hC2;

   // Request actions
   typedef enum logic [2:0] {
      ACT_TRIGGER = 3'd0,
      ACT_READ    = 3'd1,
      ACT_WRITE   = 3'd2,
      ACT_POP     = 3'd3,
      ACT_PEEK    = 3'd4
   } action_type;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_APPLY = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // One queue entry
   typedef struct packed {
      logic [15:0] code;
      logic [1:0]  kind;
   } entry_type;

   // Circular index advance; idx + n stays below twice the depth
   function automatic logic [QIDX_W-1:0] wrap_add(input logic [QIDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0]  n);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(idx) + SUM_W'(n);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return QIDX_W'(sum);
   endfunction

   // Active-slot mask for the n oldest events, capped at the slot count
   function automatic logic [MEMORY_SLOTS-1:0] slot_mask(input logic [CNT_W-1:0] n);
      logic [MEMORY_SLOTS-1:0] mask;
      for (int i = 0; i < MEMORY_SLOTS; i++) begin
         mask[i] = (int'(n) > i);
      end
      return mask;
   endfunction

endpackage

@@ rtl/device_event_queue_with_event_memory.sv @@
// ----------------------------------------------------------------------------
// device_event_queue_with_event_memory
// Circular event queue with a frozen-on-read event memory image.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result has been shown. After the request is applied, the sequencer
// walks the events queued after it (0 to 8 at a queue depth of 8) in the queue
// RAM one entry per cycle through its single read port, taking the highest
// severity and, when the event memory is rebuilt, the six oldest events on the
// same pass. The result is on the rsp_ ports for exactly one cycle, marked by
// rsp_valid; it cannot be held off, so the receiver must take it in that cycle.
module device_event_queue_with_event_memory (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  devq_pkg::action_type req_action,
   input  logic [15:0]          req_event_code,
   input  logic [1:0]           req_event_type,
   input  logic [7:0]           req_address,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_read_data,
   output logic                 rsp_event_flag,
   output logic                 rsp_events_pending,
   output logic [1:0]           rsp_highest_severity,
   output logic                 rsp_head_valid,
   output logic [15:0]          rsp_head_code,
   output logic [1:0]           rsp_head_type
);
   import devq_pkg::*;

   // Sequencer and queue control
   state_type               state_ff, state_in;
   logic [QIDX_W-1:0]       oldest_ff, oldest_in;
   logic [QIDX_W-1:0]       next_ff, next_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    frozen_ff, frozen_in;
   logic                    flag_ff, flag_in;
   logic                    rebuild_ff, rebuild_in;
   logic                    head_cap_ff, head_cap_in;
   logic [CNT_W-1:0]        walk_idx_ff, walk_idx_in;
   logic                    cap_valid_ff, cap_valid_in;
   logic [CNT_W-1:0]        cap_idx_ff, cap_idx_in;
   logic [MEMORY_SLOTS-1:0] active_ff, active_in;
   logic [1:0]              sev_ff, sev_in;
   logic                    head_valid_ff, head_valid_in;

   // Request and result payload
   action_type              act_ff;
   logic [15:0]             code_ff;
   logic [1:0]              kind_ff;
   logic [7:0]              addr_ff;
   logic [15:0]             head_code_ff, head_code_in;
   logic [1:0]              head_type_ff, head_type_in;

   // Queue RAM
   entry_type               qmem [QUEUE_DEPTH];
   entry_type               rdata_ff;
   logic [QIDX_W-1:0]       raddr;
   logic                    wr_en;

   // Event memory slots
   logic [15:0]             slot_code_ff [MEMORY_SLOTS];
   logic [1:0]              slot_type_ff [MEMORY_SLOTS];
   logic                    slot_wr;

   logic [CNT_W-1:0]        acked;
   logic [CNT_W-1:0]        remain;
   logic                    issue;
   logic [7:0]              rd_byte;

   assign acked  = (int'(count_ff) > MEMORY_SLOTS) ? CNT_W'(MEMORY_SLOTS) : count_ff;
   assign remain = count_ff - acked;
   assign issue  = (walk_idx_ff < count_ff);

   // Sequencer next state and queue bookkeeping
   always_comb begin
      state_in      = state_ff;
      oldest_in     = oldest_ff;
      next_in       = next_ff;
      count_in      = count_ff;
      frozen_in     = frozen_ff;
      flag_in       = flag_ff;
      rebuild_in    = rebuild_ff;
      head_cap_in   = head_cap_ff;
      walk_idx_in   = walk_idx_ff;
      cap_valid_in  = 1'b0;
      cap_idx_in    = walk_idx_ff;
      active_in     = active_ff;
      sev_in        = sev_ff;
      head_valid_in = head_valid_ff;
      head_code_in  = head_code_ff;
      head_type_in  = head_type_ff;
      raddr         = wrap_add(oldest_ff, walk_idx_ff);
      wr_en         = 1'b0;
      slot_wr       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_APPLY;
            end
         end

         ST_APPLY: begin
            state_in      = ST_WALK;
            rebuild_in    = 1'b0;
            head_cap_in   = 1'b0;
            walk_idx_in   = '0;
            sev_in        = '0;
            head_valid_in = 1'b0;
            head_code_in  = '0;
            head_type_in  = '0;
            raddr         = oldest_ff;
            unique case (act_ff)
               ACT_TRIGGER: begin
                  wr_en   = 1'b1;
                  next_in = wrap_add(next_ff, CNT_W'(1));
                  if (int'(count_ff) >= QUEUE_DEPTH) begin
                     oldest_in = wrap_add(oldest_ff, CNT_W'(1));
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
                  if (!frozen_ff) begin
                     rebuild_in = 1'b1;
                     active_in  = slot_mask(count_in);
                  end
                  flag_in = 1'b1;
               end
               ACT_READ: begin
                  if (int'(addr_ff) < MEM_BYTES && !frozen_ff && count_ff != '0) begin
                     rebuild_in = 1'b1;
                     frozen_in  = 1'b1;
                     active_in  = slot_mask(count_ff);
                  end
               end
               ACT_WRITE: begin
                  if (addr_ff == 8'd0) begin
                     oldest_in = wrap_add(oldest_ff, acked);
                     count_in  = remain;
                     if (remain != '0) begin
                        rebuild_in = 1'b1;
                        frozen_in  = 1'b1;
                        flag_in    = 1'b1;
                        active_in  = slot_mask(remain);
                     end else begin
                        frozen_in = 1'b0;
                        flag_in   = 1'b0;
                        active_in = '0;
                     end
                  end
               end
               ACT_POP, ACT_PEEK: begin
                  if (count_ff != '0) begin
                     head_valid_in = 1'b1;
                     head_cap_in   = 1'b1;
                     if (act_ff == ACT_POP) begin
                        oldest_in = wrap_add(oldest_ff, CNT_W'(1));
                        count_in  = count_ff - CNT_W'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         ST_WALK: begin
            // head entry was read in the apply cycle
            if (head_cap_ff) begin
               head_code_in = rdata_ff.code;
               head_type_in = rdata_ff.kind;
               head_cap_in  = 1'b0;
            end
            // one queue read issued per cycle, captured the next
            if (issue) begin
               walk_idx_in  = walk_idx_ff + CNT_W'(1);
               cap_valid_in = 1'b1;
            end
            if (cap_valid_ff) begin
               if (rdata_ff.kind > sev_ff) begin
                  sev_in = rdata_ff.kind;
               end
               slot_wr = rebuild_ff && (int'(cap_idx_ff) < MEMORY_SLOTS);
            end
            if (!issue && !cap_valid_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         oldest_ff     <= '0;
         next_ff       <= '0;
         count_ff      <= '0;
         frozen_ff     <= 1'b0;
         flag_ff       <= 1'b0;
         rebuild_ff    <= 1'b0;
         head_cap_ff   <= 1'b0;
         walk_idx_ff   <= '0;
         cap_valid_ff  <= 1'b0;
         cap_idx_ff    <= '0;
         active_ff     <= '0;
         sev_ff        <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         next_ff       <= next_in;
         count_ff      <= count_in;
         frozen_ff     <= frozen_in;
         flag_ff       <= flag_in;
         rebuild_ff    <= rebuild_in;
         head_cap_ff   <= head_cap_in;
         walk_idx_ff   <= walk_idx_in;
         cap_valid_ff  <= cap_valid_in;
         cap_idx_ff    <= cap_idx_in;
         active_ff     <= active_in;
         sev_ff        <= sev_in;
         head_valid_ff <= head_valid_in;
      end
   end

   // Request capture and head result
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         act_ff  <= req_action;
         code_ff <= req_event_code;
         kind_ff <= req_event_type;
         addr_ff <= req_address;
      end
      head_code_ff <= head_code_in;
      head_type_ff <= head_type_in;
   end

   // Queue RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         qmem[next_ff] <= '{code: code_ff, kind: kind_ff};
      end
      rdata_ff <= qmem[raddr];
   end

   // Event memory slot fill during the walk
   always_ff @(posedge clock) begin
      if (slot_wr) begin
         slot_code_ff[cap_idx_ff[$clog2(MEMORY_SLOTS + 1)-1:0]] <= rdata_ff.code;
         slot_type_ff[cap_idx_ff[$clog2(MEMORY_SLOTS + 1)-1:0]] <= rdata_ff.kind;
      end
   end

   // Event memory byte view; inactive slots and an empty image read as zero
   always_comb begin
      rd_byte = '0;
      if (act_ff == ACT_READ) begin
         if (addr_ff == 8'd0 && active_ff != '0) begin
            rd_byte = STATUS_BASE | 8'(active_ff);
         end
         for (int i = 0; i < MEMORY_SLOTS; i++) begin
            if (active_ff[i]) begin
               if (addr_ff == 8'(1 + 3 * i)) begin
                  rd_byte = QUAL_BASE | {2'b00, slot_type_ff[i], 4'b0000};
               end
               if (addr_ff == 8'(2 + 3 * i)) begin
                  rd_byte = slot_code_ff[i][15:8];
               end
               if (addr_ff == 8'(3 + 3 * i)) begin
                  rd_byte = slot_code_ff[i][7:0];
               end
            end
         end
      end
   end

   // Result ports
   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = (state_ff == ST_DONE);
   assign rsp_read_data        = rd_byte;
   assign rsp_event_flag       = flag_ff;
   assign rsp_events_pending   = (count_ff != '0);
   assign rsp_highest_severity = sev_ff;
   assign rsp_head_valid       = head_valid_ff;
   assign rsp_head_code        = head_code_ff;
   assign rsp_head_type        = head_type_ff;

   // Checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= QUEUE_DEPTH)
      else $error("queue count above depth");

   a_empty_severity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_events_pending) |-> (rsp_highest_severity == 2'd0))
      else $error("severity nonzero with empty queue");

   a_head_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_head_valid) |-> (rsp_head_code == 16'd0 && rsp_head_type == 2'd0))
      else $error("head fields set without a head event");

endmodule
